FILE: sv/tked_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tked_pkg
// key codes, byte constants, decoder state type and symbol classifier shared
// by the terminal key escape decoder
// ----------------------------------------------------------------------------
package tked_pkg;

    localparam int ByteW = 8;
    localparam int CodeW = 4;
    localparam int CharW = 7;
    localparam int PosW  = 2;
    localparam int OutDataW = ((CodeW + CharW + 7) / 8) * 8;

    typedef enum logic [CodeW-1:0] {
        KC_UNKNOWN   = 4'd0,
        KC_ESCAPE    = 4'd1,
        KC_DELETE    = 4'd2,
        KC_END       = 4'd3,
        KC_HOME      = 4'd4,
        KC_UP        = 4'd5,
        KC_DOWN      = 4'd6,
        KC_FORWARD   = 4'd7,
        KC_BACKWARD  = 4'd8,
        KC_ENTER     = 4'd9,
        KC_TAB       = 4'd10,
        KC_BACKSPACE = 4'd11,
        KC_DIGIT     = 4'd12,
        KC_LETTER    = 4'd13,
        KC_SYMBOL    = 4'd14
    } key_code_t;

    // sequence positions
    localparam logic [PosW-1:0] POS_IDLE  = 2'd0;
    localparam logic [PosW-1:0] POS_ESC   = 2'd1;
    localparam logic [PosW-1:0] POS_CSI   = 2'd2;
    localparam logic [PosW-1:0] POS_TILDE = 2'd3;

    // byte values
    localparam logic [ByteW-1:0] B_ESC     = 8'h1B;
    localparam logic [ByteW-1:0] B_LBRACK  = 8'h5B;
    localparam logic [ByteW-1:0] B_THREE   = 8'h33;
    localparam logic [ByteW-1:0] B_TILDE   = 8'h7E;
    localparam logic [ByteW-1:0] B_END     = 8'h46;
    localparam logic [ByteW-1:0] B_HOME    = 8'h48;
    localparam logic [ByteW-1:0] B_UP      = 8'h41;
    localparam logic [ByteW-1:0] B_DOWN    = 8'h42;
    localparam logic [ByteW-1:0] B_FORWARD = 8'h43;
    localparam logic [ByteW-1:0] B_BACK    = 8'h44;
    localparam logic [ByteW-1:0] B_LF      = 8'h0A;
    localparam logic [ByteW-1:0] B_TAB     = 8'h09;
    localparam logic [ByteW-1:0] B_DEL     = 8'h7F;
    localparam logic [ByteW-1:0] B_SPACE   = 8'h20;

    typedef struct packed {
        logic                  in_escape;
        logic [PosW-1:0]       seq_position;
        key_code_t             pending_code;
        logic [CharW-1:0]      pending_char;
    } dec_state_t;

    // printable punctuation, space included, square brackets, equals and grave accent left out
    function automatic logic is_symbol(input logic [ByteW-1:0] b);
        logic hit;
        hit = 1'b0;
        if (b >= B_SPACE && b <= 8'h2F) hit = 1'b1;
        if (b >= 8'h3A && b <= 8'h3C) hit = 1'b1;
        if (b >= 8'h3E && b <= 8'h40) hit = 1'b1;
        if (b == 8'h5C || b == 8'h5E || b == 8'h5F) hit = 1'b1;
        if (b >= 8'h7B && b <= B_TILDE) hit = 1'b1;
        return hit;
    endfunction

endpackage
`default_nettype wire

FILE: sv/tked_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tked_step
// next-state and emitted key for one byte, given the current decoder state
// ----------------------------------------------------------------------------
module tked_step (
    input  wire tked_pkg::dec_state_t                cur,
    input  wire logic [tked_pkg::ByteW-1:0]          in_byte,
    input  wire logic                                chunk_end,
    output tked_pkg::dec_state_t                     nxt,
    output tked_pkg::key_code_t                      key_code,
    output logic [tked_pkg::CharW-1:0]               visible_char
);
    import tked_pkg::*;

    dec_state_t upd;

    always_comb
    begin
        upd = cur;
        if (cur.in_escape)
        begin
            unique case (cur.seq_position)
                POS_ESC:
                begin
                    if (in_byte == B_LBRACK)
                    begin
                        upd.seq_position = POS_CSI;
                        upd.pending_code = KC_ESCAPE;
                    end
                end
                POS_CSI:
                begin
                    unique case (in_byte)
                        B_END:     upd.pending_code = KC_END;
                        B_HOME:    upd.pending_code = KC_HOME;
                        B_UP:      upd.pending_code = KC_UP;
                        B_DOWN:    upd.pending_code = KC_DOWN;
                        B_FORWARD: upd.pending_code = KC_FORWARD;
                        B_BACK:    upd.pending_code = KC_BACKWARD;
                        B_THREE:
                        begin
                            upd.seq_position = POS_TILDE;
                            upd.pending_code = KC_ESCAPE;
                        end
                        default:   upd = cur;
                    endcase
                end
                POS_TILDE:
                begin
                    if (in_byte == B_TILDE)
                        upd.pending_code = KC_DELETE;
                end
                default: upd = cur;
            endcase
        end
        else
        begin
            priority if (in_byte == B_ESC)
            begin
                upd.in_escape    = 1'b1;
                upd.seq_position = cur.seq_position + PosW'(1);
                upd.pending_code = KC_ESCAPE;
            end
            else if (in_byte == B_LF)
                upd.pending_code = KC_ENTER;
            else if (in_byte == B_TAB)
                upd.pending_code = KC_TAB;
            else if (in_byte == B_DEL)
                upd.pending_code = KC_BACKSPACE;
            else if (is_symbol(in_byte))
            begin
                upd.pending_code = KC_SYMBOL;
                upd.pending_char = in_byte[CharW-1:0];
            end
            else if ((in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h5A))
            begin
                upd.pending_code = KC_LETTER;
                upd.pending_char = in_byte[CharW-1:0];
            end
            else if (in_byte >= 8'h30 && in_byte <= 8'h39)
            begin
                upd.pending_code = KC_DIGIT;
                upd.pending_char = in_byte[CharW-1:0];
            end
            else
                upd = cur;
        end
    end

    always_comb
    begin
        key_code     = upd.pending_code;
        visible_char = upd.pending_char;
        nxt          = upd;
        if (chunk_end)
        begin
            // escape state survives a chunk that ended mid-sequence
            if (upd.pending_code != KC_UNKNOWN && upd.pending_code != KC_ESCAPE)
            begin
                nxt.in_escape    = 1'b0;
                nxt.seq_position = POS_IDLE;
            end
            nxt.pending_code = KC_UNKNOWN;
            nxt.pending_char = '0;
        end
    end

endmodule
`default_nettype wire

FILE: sv/terminal_key_escape_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit
// decodes raw terminal bytes into key codes, one key per read chunk
// ----------------------------------------------------------------------------
// usage
//   slave side: one terminal byte per item in s_tdata, s_tlast marks the
//   last byte of a read chunk. bytes inside a chunk only update the
//   pending key; the last byte of a chunk produces one result item
//   - master side: m_tdata carries the key code and the visible character
//   of the chunk (letters, digits, symbols), 0 if the chunk had none
//   - path: input register, decode, then result register on the master side
//   - throughput: one byte per cycle unless a chunk-ending byte waits on
//   a full result register; the decode is a single byte compare plus
//   state update between the input register and the result register
//   - stall: while a result waits on m_tready, bytes that end no chunk keep
//   flowing; a chunk-ending byte waits in the input register, and
//   s_tready drops only once that register is also full
//   - reset: escape state, sequence position and pending key are cleared,
//   both registers are emptied
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [tked_pkg::ByteW-1:0]            s_tdata,  // [7:0] in_byte
    input  wire logic                                  s_tlast,  // chunk_end
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [3:0] key_code, [10:4] visible_char, [15:11] zero
    output logic [tked_pkg::OutDataW-1:0]              m_tdata
);
    import tked_pkg::*;

    // input register
    logic                in_valid_reg;
    logic [ByteW-1:0]    in_byte_reg;
    logic                in_last_reg;

    // decoder state
    dec_state_t          state_reg;
    dec_state_t          state_next;

    // result register
    logic                out_valid_reg;
    key_code_t           out_code_reg;
    logic [CharW-1:0]    out_char_reg;

    key_code_t           step_code;
    logic [CharW-1:0]    step_char;
    logic                out_free;
    logic                advance;

    tked_step u_step (
        .cur          (state_reg),
        .in_byte      (in_byte_reg),
        .chunk_end    (in_last_reg),
        .nxt          (state_next),
        .key_code     (step_code),
        .visible_char (step_char)
    );

    // result slot is free if empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // a byte with no chunk end never needs the result slot
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{in_escape: 1'b0, seq_position: POS_IDLE,
                               pending_code: KC_UNKNOWN, pending_char: '0};
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                state_reg <= state_next;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_code_reg <= step_code;
            out_char_reg <= step_char;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OutDataW - CodeW - CharW)'(0), out_char_reg, out_code_reg};

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams terminal bytes into the key escape decoder under random gaps and
// back-pressure, predicts each chunk's key code and character, and checks
// every result item in order
// ----------------------------------------------------------------------------
module testbench;
    import tked_pkg::*;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } term_byte_t;

    typedef struct packed {
        key_code_t        code;
        logic [CharW-1:0] ch;
    } key_result_t;

    localparam int ByteTarget = 1400;
    localparam int HoldCycles = 400;
    localparam int HoldAfter  = 150;
    localparam int IdleLimit  = 5000;
    localparam int DrainWait  = 12;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ByteW-1:0]    s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    term_byte_t  pending_bytes[$];
    key_result_t expected_keys[$];

    // decoder state as seen by the predictor
    logic             esc_active = 1'b0;
    logic [PosW-1:0]  esc_pos = POS_IDLE;
    key_code_t        held_code = KC_UNKNOWN;
    logic [CharW-1:0] held_char = '0;

    logic        byte_taken = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          idle_cycles = 0;
    logic [11:0] cycle_count = '0;
    logic [15:0] codes_seen = '0;
    int          bytes_accepted = 0;
    int          keys_checked = 0;
    int          mismatches = 0;

    // stretches with no new random gaps or stalls on either side
    wire quiet = (cycle_count[8:6] == 3'd0);

    terminal_key_escape_decoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // printable punctuation: space, !../, :;<, >?@, \ ^ _, {|}~
    function automatic logic punct_byte(input logic [ByteW-1:0] b);
        case (b)
            8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
            8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
            8'h3A, 8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h40, 8'h5C, 8'h5E,
            8'h5F, 8'h7B, 8'h7C, 8'h7D, 8'h7E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // update the pending key with one byte; a chunk end queues the key
    task automatic decode_byte(input term_byte_t tb);
        key_result_t r;
        if (esc_active)
        begin
            case (esc_pos)
                POS_ESC:
                    if (tb.data == B_LBRACK)
                    begin
                        esc_pos   = POS_CSI;
                        held_code = KC_ESCAPE;
                    end
                POS_CSI:
                    case (tb.data)
                        B_END:     held_code = KC_END;
                        B_HOME:    held_code = KC_HOME;
                        B_UP:      held_code = KC_UP;
                        B_DOWN:    held_code = KC_DOWN;
                        B_FORWARD: held_code = KC_FORWARD;
                        B_BACK:    held_code = KC_BACKWARD;
                        B_THREE:
                        begin
                            esc_pos   = POS_TILDE;
                            held_code = KC_ESCAPE;
                        end
                        default: ;
                    endcase
                POS_TILDE:
                    if (tb.data == B_TILDE)
                        held_code = KC_DELETE;
                default: ;
            endcase
        end
        else if (tb.data == B_ESC)
        begin
            esc_active = 1'b1;
            esc_pos    = esc_pos + PosW'(1);
            held_code  = KC_ESCAPE;
        end
        else if (tb.data == B_LF)
            held_code = KC_ENTER;
        else if (tb.data == B_TAB)
            held_code = KC_TAB;
        else if (tb.data == B_DEL)
            held_code = KC_BACKSPACE;
        else if (punct_byte(tb.data))
        begin
            held_code = KC_SYMBOL;
            held_char = tb.data[CharW-1:0];
        end
        else if ((tb.data >= 8'h61 && tb.data <= 8'h7A) ||
                 (tb.data >= 8'h41 && tb.data <= 8'h5A))
        begin
            held_code = KC_LETTER;
            held_char = tb.data[CharW-1:0];
        end
        else if (tb.data >= 8'h30 && tb.data <= 8'h39)
        begin
            held_code = KC_DIGIT;
            held_char = tb.data[CharW-1:0];
        end

        if (tb.last)
        begin
            r.code = held_code;
            r.ch   = held_char;
            expected_keys.push_back(r);
            // an unfinished sequence survives the chunk end
            if (held_code != KC_UNKNOWN && held_code != KC_ESCAPE)
            begin
                esc_active = 1'b0;
                esc_pos    = POS_IDLE;
            end
            held_code = KC_UNKNOWN;
            held_char = '0;
        end
    endtask

    task automatic add_byte(input logic [ByteW-1:0] data, input logic last);
        term_byte_t tb;
        tb.data = data;
        tb.last = last;
        pending_bytes.push_back(tb);
    endtask

    // one random chunk: mostly well-formed keys, some noise and broken sequences
    task automatic add_random_chunk();
        logic [ByteW-1:0] seq_bytes[$];
        logic [ByteW-1:0] tail;
        int               kind;
        int               n;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            if ($urandom_range(0, 3) == 0)
                add_byte(ByteW'($urandom_range(0, 255)), 1'b1);
            else
                add_byte(ByteW'($urandom_range(8'h20, 8'h7F)), 1'b1);
        end
        else if (kind < 50)
        begin
            n = $urandom_range(2, 5);
            for (int i = 0; i < n; i++)
                add_byte(ByteW'($urandom_range(0, 255)), i == n - 1);
        end
        else if (kind < 85)
        begin
            seq_bytes.push_back(B_ESC);
            seq_bytes.push_back(B_LBRACK);
            case ($urandom_range(0, 6))
                0: tail = B_END;
                1: tail = B_HOME;
                2: tail = B_UP;
                3: tail = B_DOWN;
                4: tail = B_FORWARD;
                5: tail = B_BACK;
                default: tail = B_THREE;
            endcase
            seq_bytes.push_back(tail);
            if (tail == B_THREE)
                seq_bytes.push_back(B_TILDE);
            // broken forms: stray byte inside, or the final byte missing
            if ($urandom_range(0, 9) == 0)
                seq_bytes.insert($urandom_range(1, seq_bytes.size() - 1),
                                 ByteW'($urandom_range(0, 255)));
            else if ($urandom_range(0, 9) == 0)
                void'(seq_bytes.pop_back());
            // split across chunks at random points now and then
            for (int i = 0; i < seq_bytes.size(); i++)
                add_byte(seq_bytes[i],
                         i == seq_bytes.size() - 1 || $urandom_range(0, 4) == 0);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // byte driver: holds an item until taken, then an optional gap
    always @(negedge clk)
    begin : drive_bytes
        term_byte_t tb;
        if (!rst_n || (s_tvalid && !byte_taken))
        begin
        end
        else if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_bytes.size() > 0)
        begin
            tb = pending_bytes.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= tb.data;
            s_tlast  <= tb.last;
            send_gap <= (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        end
        else
            s_tvalid <= 1'b0;
    end

    // result receiver: random stalls plus one long hold-off that fills the block
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && keys_checked >= HoldAfter)
        begin
            m_tready  <= 1'b0;
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check delivered keys first, then predict from the accepted byte
    always @(posedge clk)
    begin : check_keys
        key_result_t want;
        term_byte_t  tb;
        cycle_count <= cycle_count + 1'b1;
        byte_taken  <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                keys_checked++;
                codes_seen[m_tdata[CodeW-1:0]] = 1'b1;
                if (expected_keys.size() == 0)
                begin
                    $error("key item with none expected: m_tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (m_tdata[CodeW-1:0] !== want.code)
                    begin
                        $error("key_code: expected %0d, actual %0d",
                               want.code, m_tdata[CodeW-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[CodeW+CharW-1:CodeW] !== want.ch)
                    begin
                        $error("visible_char: expected %h, actual %h",
                               want.ch, m_tdata[CodeW+CharW-1:CodeW]);
                        mismatches++;
                    end
                    if (m_tdata[OutDataW-1:CodeW+CharW] !== '0)
                    begin
                        $error("pad: expected 0, actual %h",
                               m_tdata[OutDataW-1:CodeW+CharW]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                tb.data = s_tdata;
                tb.last = s_tlast;
                bytes_accepted++;
                decode_byte(tb);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        // single-byte chunks: extremes and control keys
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h80, 1'b1);
        add_byte(B_DEL, 1'b1);
        add_byte(B_TAB, 1'b1);
        // enter keeps the letter seen earlier in the chunk
        add_byte(8'h61, 1'b0);
        add_byte(B_LF, 1'b1);
        // later visible bytes overwrite earlier ones
        add_byte(B_SPACE, 1'b0);
        add_byte(B_TILDE, 1'b0);
        add_byte(8'h35, 1'b1);
        // '=' is neither symbol nor letter
        add_byte(8'h3D, 1'b1);
        // delete split one byte per chunk: escape state survives the chunk ends
        add_byte(B_ESC, 1'b1);
        add_byte(B_LBRACK, 1'b1);
        add_byte(B_THREE, 1'b1);
        add_byte(B_TILDE, 1'b1);
        add_byte(B_ESC, 1'b0);
        add_byte(B_LBRACK, 1'b0);
        add_byte(B_HOME, 1'b1);
        // stray byte and repeated escape inside a sequence are ignored
        add_byte(B_ESC, 1'b0);
        add_byte(8'h78, 1'b0);
        add_byte(B_ESC, 1'b0);
        add_byte(B_LBRACK, 1'b0);
        add_byte(B_END, 1'b1);
        add_byte(B_ESC, 1'b0);
        add_byte(B_LBRACK, 1'b0);
        add_byte(B_UP, 1'b1);

        while (pending_bytes.size() < ByteTarget)
            add_random_chunk();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || s_tvalid || expected_keys.size() > 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        $display("%0d bytes accepted, %0d key items checked, long output hold-off %0s",
                 bytes_accepted, keys_checked, hold_done ? "done" : "not reached");
        $display("%0d of 15 key codes delivered", $countones(codes_seen));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
